>>> sv/ira_pkg.sv
// ----------------------------------------------------------------------------
// Integer to radix ASCII package
// Shared types, constants and the digit-to-character function for the
// integer to radix ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ira_pkg;

	localparam int DIGIT_BITS    = 6;
	localparam int CHAR_BITS     = 7;
	localparam int BITS_PER_STEP = 8;

	localparam logic [DIGIT_BITS-1:0] BASE_MIN = 6'd2;
	localparam logic [DIGIT_BITS-1:0] BASE_MAX = 6'd36;
	localparam logic [DIGIT_BITS-1:0] BASE_DEC = 6'd10;
	localparam logic [DIGIT_BITS-1:0] BASE_HEX = 6'd16;
	localparam logic [DIGIT_BITS-1:0] DEC_DIGITS = 6'd10;

	localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_UPPER = 7'h41;
	localparam logic [CHAR_BITS-1:0] CHAR_LOWER = 7'h61;
	localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_BITS-1:0] CHAR_NONE  = 7'h00;

	typedef enum logic {
		OP_RADIX = 1'b0,
		OP_HEX   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_DIV,
		ST_NEXT,
		ST_SIGN,
		ST_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic push;
		logic rd;
		logic emit_sign;
		logic emit_digit;
		logic emit_err;
	} cmd_t;

	typedef struct packed {
		logic base_bad;
		logic div_done;
		logic q_zero;
		logic cnt_zero;
		logic out_free;
	} status_t;

	function automatic logic [CHAR_BITS-1:0] digit_char(
		input logic [DIGIT_BITS-1:0] d,
		input logic                  lower
	);
		logic [CHAR_BITS-1:0] dx;
		dx = CHAR_BITS'(d);
		if (d < DEC_DIGITS) begin
			return CHAR_ZERO + dx;
		end else if (lower) begin
			return CHAR_LOWER + dx - CHAR_BITS'(DEC_DIGITS);
		end else begin
			return CHAR_UPPER + dx - CHAR_BITS'(DEC_DIGITS);
		end
	endfunction

endpackage

`default_nettype wire

>>> sv/ira_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/ira_ctrl.sv
// ----------------------------------------------------------------------------
// Integer to radix ASCII controller
// Sequences load, digit division, digit push, stack read and character emission.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             neg,
	input  wire ira_pkg::status_t sts,
	output ira_pkg::cmd_t         cmd
);

	import ira_pkg::*;

	state_t st_q;
	state_t st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					st_d = sts.base_bad ? ST_ERR : ST_DIV;
				end
			end
			ST_ERR: begin
				if (sts.out_free) begin
					st_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					st_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (!sts.q_zero) begin
					st_d = ST_DIV;
				end else if (neg) begin
					st_d = ST_SIGN;
				end else begin
					st_d = ST_RD;
				end
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					st_d = ST_RD;
				end
			end
			ST_RD: begin
				st_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					st_d = sts.cnt_zero ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_ERR:  cmd.emit_err   = sts.out_free;
			ST_DIV:  cmd.div_step   = 1'b1;
			ST_NEXT: cmd.push       = 1'b1;
			ST_SIGN: cmd.emit_sign  = sts.out_free;
			ST_RD:   cmd.rd         = 1'b1;
			ST_EMIT: cmd.emit_digit = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/ira_dp.sv
// ----------------------------------------------------------------------------
// Integer to radix ASCII datapath
// Holds the running quotient, the shared radix divider, the digit stack and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ira_dp #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  op,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic [5:0]            base,
	input  wire ira_pkg::cmd_t         cmd,
	output ira_pkg::status_t           sts,
	output logic                       neg,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [6:0]                 ch,
	output logic                       last,
	output logic                       error
);

	import ira_pkg::*;

	localparam int STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int QW    = STEPS * BITS_PER_STEP;
	localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int CW    = $clog2(VALUE_BITS + 1);
	localparam int AW    = $clog2(VALUE_BITS);

	logic [DIGIT_BITS-1:0] radix_q;
	logic                  lower_q;
	logic                  neg_q;
	logic [QW-1:0]         w_q;
	logic [DIGIT_BITS-1:0] rem_q;
	logic [SW-1:0]         step_q;
	logic [CW-1:0]         cnt_q;
	logic                  out_valid_q;
	logic [CHAR_BITS-1:0]  ch_q;
	logic                  last_q;
	logic                  err_q;

	logic                  is_hex;
	logic                  neg_in;
	logic [VALUE_BITS-1:0] mag_in;
	logic [QW-1:0]         w_next;
	logic [DIGIT_BITS-1:0] rem_next;
	logic [CW-1:0]         cnt_dec;
	logic [DIGIT_BITS-1:0] rd_digit;

	assign is_hex = (op == OP_HEX);
	assign neg_in = !is_hex && (base == BASE_DEC) && value[VALUE_BITS-1];
	assign mag_in = neg_in ? (~value + VALUE_BITS'(1)) : value;
	assign cnt_dec = cnt_q - CW'(1);

	always_comb begin
		logic [DIGIT_BITS:0] t;
		logic                ge;
		w_next   = w_q;
		rem_next = rem_q;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			t  = {rem_next, w_next[QW-1]};
			ge = (t >= {1'b0, radix_q});
			if (ge) begin
				t = t - {1'b0, radix_q};
			end
			rem_next = t[DIGIT_BITS-1:0];
			w_next   = {w_next[QW-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			radix_q <= is_hex ? BASE_HEX : base;
			lower_q <= is_hex;
			neg_q   <= neg_in;
			w_q     <= QW'(mag_in);
			rem_q   <= '0;
			step_q  <= '0;
		end else if (cmd.div_step) begin
			w_q    <= w_next;
			rem_q  <= rem_next;
			step_q <= step_q + SW'(1);
		end else if (cmd.push) begin
			rem_q  <= '0;
			step_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.push) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.rd) begin
			cnt_q <= cnt_dec;
		end
	end

	ira_ram #(
		.WIDTH(DIGIT_BITS),
		.DEPTH(VALUE_BITS)
	) u_stack (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(cnt_q[AW-1:0]),
		.wdata(rem_q),
		.re   (cmd.rd),
		.raddr(cnt_dec[AW-1:0]),
		.rdata(rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			ch_q   <= CHAR_MINUS;
			last_q <= 1'b0;
			err_q  <= 1'b0;
		end else if (cmd.emit_digit) begin
			ch_q   <= digit_char(rd_digit, lower_q);
			last_q <= (cnt_q == '0);
			err_q  <= 1'b0;
		end else if (cmd.emit_err) begin
			ch_q   <= CHAR_NONE;
			last_q <= 1'b1;
			err_q  <= 1'b1;
		end
	end

	assign sts.base_bad = !is_hex && ((base < BASE_MIN) || (base > BASE_MAX));
	assign sts.div_done = (step_q == SW'(STEPS - 1));
	assign sts.q_zero   = (w_q == '0);
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	assign neg       = neg_q;
	assign out_valid = out_valid_q;
	assign ch        = ch_q;
	assign last      = last_q;
	assign error     = err_q;

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (rem_q < radix_q))
		else $error("digit remainder not below radix");

	a_stack_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (cnt_q < CW'(VALUE_BITS)))
		else $error("digit stack overflow");

	a_stack_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (cnt_q != '0))
		else $error("digit stack read while empty");

	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sign || cmd.emit_digit || cmd.emit_err) |-> sts.out_free)
		else $error("character overwrote a pending output");

endmodule

`default_nettype wire

>>> sv/integer_to_radix_ascii.sv
// Sequence: a load, then per digit the shared radix divider, which retires 8 quotient bits
// per cycle over STEPS = ceil(VALUE_BITS / 8) divider steps, and a digit push; then per
// character a stack read and an output load, plus a minus sign where needed.
// One request is converted at a time; the next is taken while the final character waits.
// Reset (arst_n low, asynchronous) clears control state; the digit stack is not cleared.
// ----------------------------------------------------------------------------
// Integer to radix ASCII converter
// Converts a value to ASCII digits in base 2 to 36 or lowercase hex, one character per
// response, most significant first; a negative decimal value gets a minus, a bad base an error.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_ascii #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  op,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic [5:0]            base,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [6:0]                 ch,
	output logic                       last,
	output logic                       error
);

	import ira_pkg::*;

	cmd_t    cmd;
	status_t sts;
	logic    neg;

	ira_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.neg     (neg),
		.sts     (sts),
		.cmd     (cmd)
	);

	ira_dp #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.value    (value),
		.base     (base),
		.cmd      (cmd),
		.sts      (sts),
		.neg      (neg),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ch       (ch),
		.last     (last),
		.error    (error)
	);

endmodule

`default_nettype wire

>>> verif/tb_integer_to_radix_ascii.sv
// ----------------------------------------------------------------------------
// Integer to radix ASCII converter testbench
// Sends conversion requests through a valid/ready channel and checks every
// character of the returned text against a predicted string. The sender
// works in random bursts, and the receiver stalls on patterns of its own.
// Directed cases cover invalid bases, signed decimal and lowercase hex.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_ascii;
	timeunit 1ns;
	timeprecision 1ps;

	import ira_pkg::*;

	localparam int NUM_RANDOM      = 300;
	localparam int HOLD_OFF_CYCLES = 1500;
	localparam int DRAIN_CYCLES    = 800;
	localparam int WATCHDOG_LIMIT  = 20000;

	typedef struct {
		logic [6:0] ch;
		logic       last;
		logic       error;
	} text_char_t;

	class radix_text_checker;
		text_char_t pending_chars[$];
		int         errors;
		string      upper_digits = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
		string      lower_digits = "0123456789abcdef";

		function void note_request(op_t kind, logic [63:0] raw, logic [5:0] radix_sel);
			logic [63:0] mag;
			logic [63:0] radix;
			logic [5:0]  digits[$];
			text_char_t  c;
			bit          hex;
			bit          neg;
			hex = (kind == OP_HEX);
			if (!hex && (radix_sel < BASE_MIN || radix_sel > BASE_MAX)) begin
				c.ch = CHAR_NONE;
				c.last = 1'b1;
				c.error = 1'b1;
				pending_chars.push_back(c);
				return;
			end
			radix = hex ? 64'd16 : 64'(radix_sel);
			neg = !hex && radix_sel == BASE_DEC && raw[63];
			mag = neg ? ~raw + 64'd1 : raw;
			do begin
				digits.push_front(6'(mag % radix));
				mag = mag / radix;
			end while (mag != 64'd0);
			if (neg) begin
				c.ch = CHAR_MINUS;
				c.last = 1'b0;
				c.error = 1'b0;
				pending_chars.push_back(c);
			end
			foreach (digits[i]) begin
				c.ch = hex ? 7'(lower_digits[digits[i]]) : 7'(upper_digits[digits[i]]);
				c.last = (i == digits.size() - 1);
				c.error = 1'b0;
				pending_chars.push_back(c);
			end
		endfunction

		function void check_char(logic [6:0] ch_got, logic last_got, logic error_got);
			text_char_t want;
			if (pending_chars.size() == 0) begin
				$error("unexpected character 0x%02h with no request pending", ch_got);
				errors++;
				return;
			end
			want = pending_chars.pop_front();
			if (ch_got !== want.ch) begin
				$error("ch mismatch: expected 0x%02h, actual 0x%02h", want.ch, ch_got);
				errors++;
			end
			if (last_got !== want.last) begin
				$error("last mismatch: expected %0b, actual %0b", want.last, last_got);
				errors++;
			end
			if (error_got !== want.error) begin
				$error("error mismatch: expected %0b, actual %0b", want.error, error_got);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        op;
	logic [63:0] value;
	logic [5:0]  base;
	logic        out_valid;
	logic        out_ready;
	logic [6:0]  ch;
	logic        last;
	logic        error;

	radix_text_checker text_sb = new();
	bit                hold_off_req = 1'b0;
	int                quiet_cycles = 0;

	integer_to_radix_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.value     (value),
		.base      (base),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ch        (ch),
		.last      (last),
		.error     (error)
	);

	always #4 clk = ~clk;

	task automatic send_request(op_t kind, logic [63:0] raw, logic [5:0] radix_sel);
		@(negedge clk);
		in_valid <= 1'b1;
		op <= kind;
		value <= raw;
		base <= radix_sel;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		text_sb.note_request(kind, raw, radix_sel);
	endtask

	task automatic idle_sender(int cycles);
		if (cycles == 0) begin
			return;
		end
		@(negedge clk);
		in_valid <= 1'b0;
		op <= 1'($urandom);
		value <= {$urandom, $urandom};
		base <= 6'($urandom);
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic make_request(output op_t kind, output logic [63:0] raw,
			output logic [5:0] radix_sel);
		logic [63:0] small_val;
		small_val = 64'($urandom_range(0, 40));
		kind = ($urandom_range(0, 4) == 0) ? OP_HEX : OP_RADIX;
		case ($urandom_range(0, 5))
			0: begin
				raw = small_val;
			end
			1: begin
				raw = ~small_val;
			end
			2: begin
				case ($urandom_range(0, 3))
					0: raw = 64'd0;
					1: raw = '1;
					2: raw = 64'h8000_0000_0000_0000;
					default: raw = 64'h7FFF_FFFF_FFFF_FFFF;
				endcase
			end
			default: begin
				raw = {$urandom, $urandom};
			end
		endcase
		case ($urandom_range(0, 9))
			0: radix_sel = $urandom_range(0, 1) ? 6'($urandom_range(37, 63))
				: 6'($urandom_range(0, 1));
			1, 2, 3: radix_sel = BASE_DEC;
			4: radix_sel = BASE_HEX;
			default: radix_sel = 6'($urandom_range(2, 36));
		endcase
		if (kind == OP_HEX && $urandom_range(0, 1)) begin
			radix_sel = 6'($urandom);
		end
	endtask

	initial begin
		int   mode;
		int   span;
		int   tick;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(50, 300);
			for (tick = 0; tick < span; tick++) begin
				@(negedge clk);
				if (hold_off_req) begin
					out_ready <= 1'b0;
					repeat (HOLD_OFF_CYCLES) @(negedge clk);
					hold_off_req = 1'b0;
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (tick % 4 == 0);
					default: out_ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			text_sb.check_char(ch, last, error);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("integer_to_radix_ascii test failed");
			$finish;
		end
	end

	initial begin
		op_t         kind;
		logic [63:0] raw;
		logic [5:0]  radix_sel;
		int          burst_left;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_RADIX;
		value = '0;
		base = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_request(OP_RADIX, 64'd0, BASE_DEC);
		send_request(OP_RADIX, 64'd1, BASE_DEC);
		send_request(OP_RADIX, '1, BASE_DEC);
		send_request(OP_RADIX, 64'h8000_0000_0000_0000, BASE_DEC);
		send_request(OP_RADIX, 64'h7FFF_FFFF_FFFF_FFFF, BASE_DEC);
		send_request(OP_RADIX, '1, BASE_MIN);
		send_request(OP_RADIX, 64'd0, BASE_MIN);
		send_request(OP_RADIX, '1, BASE_MAX);
		send_request(OP_RADIX, 64'd35, BASE_MAX);
		send_request(OP_RADIX, 64'hFFFF_FFFF_FFFF_FF85, BASE_HEX);
		send_request(OP_RADIX, 64'h8000_0000_0000_0000, 6'd8);
		send_request(OP_RADIX, 64'd12345, 6'd0);
		send_request(OP_RADIX, 64'd12345, 6'd1);
		idle_sender(3);
		send_request(OP_RADIX, '1, 6'd37);
		send_request(OP_RADIX, 64'd7, 6'd63);
		send_request(OP_HEX, '1, 6'd0);
		send_request(OP_HEX, 64'd0, 6'd63);
		send_request(OP_HEX, 64'h0123_4567_89AB_CDEF, BASE_DEC);
		send_request(OP_HEX, 64'h8000_0000_0000_0000, 6'd5);
		send_request(OP_RADIX, 64'hDEAD_BEEF_0BAD_F00D, 6'd3);
		send_request(OP_RADIX, 64'hDEAD_BEEF_0BAD_F00D, 6'd35);
		send_request(OP_RADIX, 64'hFFFF_FFFF_FFFF_FFF6, BASE_DEC);

		burst_left = 0;
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == 120) begin
				hold_off_req = 1'b1;
			end
			if (i == 200) begin
				idle_sender(1);
				while (text_sb.pending_chars.size() != 0) begin
					@(negedge clk);
				end
			end
			if (burst_left == 0) begin
				idle_sender($urandom_range(1, 12));
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 8);
			end
			make_request(kind, raw, radix_sel);
			send_request(kind, raw, radix_sel);
			burst_left--;
		end

		idle_sender(1);
		while (text_sb.pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (text_sb.errors == 0 && text_sb.pending_chars.size() == 0) begin
			$display("integer_to_radix_ascii test passed");
		end else begin
			$display("integer_to_radix_ascii test failed");
		end
		$finish;
	end

endmodule

>>> files.f
sv/ira_pkg.sv
sv/ira_ram.sv
sv/ira_ctrl.sv
sv/ira_dp.sv
sv/integer_to_radix_ascii.sv
verif/tb_integer_to_radix_ascii.sv
